FILE: sv/pbrt_pkg.sv
// Shared codes and helpers for the piece block reservation tracker.
package pbrt_pkg;

    // Operation codes carried in the kind field of an input item
    typedef enum logic [2:0] {
        KIND_RESERVE = 3'd0,
        KIND_CANCEL  = 3'd1,
        KIND_STORE   = 3'd2,
        KIND_FLUSH   = 3'd3,
        KIND_RESTART = 3'd4
    } kind_t;

    // Result status codes
    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_REFUSED   = 3'd1,
        STAT_RANGE     = 3'd2,
        STAT_WRONG_LEN = 3'd3,
        STAT_FULL      = 3'd4
    } status_t;

    // Piece length after reset
    localparam logic [24:0] PIECE_LEN_RESET = 25'd16384;

    // Clamp a raw piece length to [1, cap]
    function automatic logic [24:0] eff_length(input logic [24:0] len, input logic [32:0] cap);
        logic [24:0] res;
        if (len == 25'd0) begin
            res = 25'd1;
        end else if ({8'd0, len} > cap) begin
            res = cap[24:0];
        end else begin
            res = len;
        end
        return res;
    endfunction

endpackage

FILE: sv/pbrt_if.sv
// Valid/ready channel interfaces for request items and result items.
interface pbrt_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [9:0]  block_index;
    logic [14:0] data_length;

    modport source (output valid, output kind, output block_index, output data_length,
                    input ready);
    modport sink   (input valid, input kind, input block_index, input data_length,
                    output ready);
endinterface

interface pbrt_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [9:0]  granted_index;
    logic        piece_complete;
    logic [24:0] missing_bytes;
    logic        sealed;

    modport source (output valid, output status, output granted_index,
                    output piece_complete, output missing_bytes, output sealed,
                    input ready);
    modport sink   (input valid, input status, input granted_index,
                    input piece_complete, input missing_bytes, input sealed,
                    output ready);
endinterface

FILE: sv/pbrt_ram.sv
// Synchronous RAM with one write port and one registered read port.
module pbrt_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 10
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read one entry, hold the data until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: sv/pbrt_geom.sv
// Clearing sweep that also counts the blocks of the piece and sizes the last one.
module pbrt_geom
    import pbrt_pkg::*;
#(
    parameter int BLOCK_BYTES = 16384,
    parameter int MAX_BLOCKS  = 1024
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         start,
    input  logic [24:0]                                  len_eff,
    output logic                                         sweep_active,
    output logic [((MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1)-1:0] sweep_addr,
    output logic [$clog2(MAX_BLOCKS+1)-1:0]              parts,
    output logic [$clog2(BLOCK_BYTES+1)-1:0]             last_len
);

    localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS+1);
    localparam int LW = $clog2(BLOCK_BYTES+1);
    localparam logic [32:0] CAP = 33'(MAX_BLOCKS) * 33'(BLOCK_BYTES);
    localparam logic [CW-1:0] LAST_STEP = CW'(MAX_BLOCKS - 1);
    localparam logic [24:0] BLK = 25'(BLOCK_BYTES);

    logic          active_reg;
    logic [CW-1:0] step_reg;
    logic [24:0]   rem_reg;
    logic [CW-1:0] parts_reg;
    logic [LW-1:0] last_reg;
    logic          fits;

    // Remaining bytes fit in one block
    assign fits = ({1'b0, rem_reg} <= {1'b0, BLK});

    // Step through every entry; peel one block off the remaining length per step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b1;
            step_reg   <= '0;
            rem_reg    <= eff_length(PIECE_LEN_RESET, CAP);
            parts_reg  <= '0;
            last_reg   <= '0;
        end
        else if (start)
        begin
            active_reg <= 1'b1;
            step_reg   <= '0;
            rem_reg    <= len_eff;
            parts_reg  <= '0;
        end
        else if (active_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                active_reg <= 1'b0;
            end
            if (rem_reg != 25'd0)
            begin
                parts_reg <= parts_reg + 1'b1;
                if (fits)
                begin
                    last_reg <= rem_reg[LW-1:0];
                    rem_reg  <= 25'd0;
                end
                else
                begin
                    rem_reg <= rem_reg - BLK;
                end
            end
        end
    end

    assign sweep_active = active_reg;
    assign sweep_addr   = step_reg[AW-1:0];
    assign parts        = parts_reg;
    assign last_len     = last_reg;

endmodule

FILE: sv/piece_block_reservation_tracker_unit.sv
// Top level of the piece block reservation tracker.
//
//  port         dir   width  what it moves
//  req          in    28     item: kind, block_index, data_length (valid/ready)
//  rsp          out   40     item: status, granted_index, piece_complete,
//                            missing_bytes, sealed (valid/ready)
//  cfg_wr_*     in    25     piece_length write, restarts the tracker
//
//  Each item passes an accept step (stored-flag and stack RAM reads issued),
//  then an execute step (read data used, RAMs written back, result registered).
//  A result waiting in the output register blocks execution of the next item,
//  not its acceptance. After reset, a restart item or a piece_length write the
//  stored-flag RAM is swept clear entry by entry; input opens only after the
//  sweep has ended, so no item is taken while it runs.
module piece_block_reservation_tracker_unit
    import pbrt_pkg::*;
#(
    parameter int BLOCK_BYTES = 16384,
    parameter int MAX_BLOCKS  = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    pbrt_req_if.sink          req,
    pbrt_rsp_if.source        rsp,
    input  logic              cfg_wr_en,
    input  logic [24:0]       cfg_wr_data
);

    localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS+1);
    localparam int LW = $clog2(BLOCK_BYTES+1);
    localparam int W  = ((CW > 10) ? CW : 10) + 1;
    localparam logic [32:0]   CAP      = 33'(MAX_BLOCKS) * 33'(BLOCK_BYTES);
    localparam logic [CW-1:0] DEPTH_MAX = CW'(MAX_BLOCKS);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;

    // Tracker state registers
    logic [24:0]   plen_reg;
    logic [CW-1:0] depth_reg, depth_next;
    logic [CW-1:0] fresh_reg, fresh_next;
    logic [CW-1:0] count_reg, count_next;
    logic [24:0]   missing_reg, missing_next;
    logic          sealed_reg, sealed_next;

    // Latched item
    logic [2:0]    kind_reg;
    logic [9:0]    idx_reg;
    logic [14:0]   dlen_reg;

    // Result register
    logic          rsp_valid_reg;
    status_t       status_reg, status_next;
    logic [9:0]    granted_reg, granted_next;
    logic          complete_reg;
    logic [24:0]   rsp_missing_reg;
    logic          rsp_sealed_reg;

    // Geometry and sweep
    logic          sweep_active;
    logic [AW-1:0] sweep_addr;
    logic [CW-1:0] parts;
    logic [LW-1:0] last_len;
    logic          geom_start;
    logic [24:0]   geom_len;
    logic [24:0]   eff_cur;

    // RAM ports
    logic          flag_rd;
    logic [AW-1:0] stack_rd;
    logic          flag_we, flag_ram_we, flag_ram_wdata;
    logic [AW-1:0] flag_ram_waddr;
    logic          stack_we;

    // Address and compare helpers
    logic          accept, exec_go, restart_go;
    logic [W-1:0]  idx_in_w, idx_w, parts_w, stack_rd_w, fresh_w;
    logic [AW-1:0] idx_in_addr, idx_addr, depth_addr, depth_m1_addr;
    logic [CW-1:0] depth_m1;
    logic          in_range, is_last, len_ok;
    logic [LW-1:0] need_len;
    logic [24:0]   dlen_w;

    assign accept     = req.valid && req.ready;
    assign exec_go    = (state_reg == ST_EXEC) && (!rsp_valid_reg || rsp.ready);
    assign restart_go = exec_go && (kind_reg == KIND_RESTART);
    assign req.ready  = (state_reg == ST_IDLE);

    assign eff_cur    = eff_length(plen_reg, CAP);
    assign geom_start = cfg_wr_en || restart_go;
    assign geom_len   = cfg_wr_en ? eff_length(cfg_wr_data, CAP) : eff_cur;

    pbrt_geom #(
        .BLOCK_BYTES (BLOCK_BYTES),
        .MAX_BLOCKS  (MAX_BLOCKS)
    ) u_geom (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (geom_start),
        .len_eff      (geom_len),
        .sweep_active (sweep_active),
        .sweep_addr   (sweep_addr),
        .parts        (parts),
        .last_len     (last_len)
    );

    // Form RAM addresses
    assign idx_in_w      = W'(req.block_index);
    assign idx_in_addr   = idx_in_w[AW-1:0];
    assign idx_w         = W'(idx_reg);
    assign idx_addr      = idx_w[AW-1:0];
    assign depth_addr    = depth_reg[AW-1:0];
    assign depth_m1      = depth_reg - 1'b1;
    assign depth_m1_addr = depth_m1[AW-1:0];

    // Sweep clears the flags; otherwise a store sets one
    assign flag_ram_we    = sweep_active || (exec_go && flag_we);
    assign flag_ram_waddr = sweep_active ? sweep_addr : idx_addr;
    assign flag_ram_wdata = !sweep_active;

    pbrt_ram #(
        .DEPTH (MAX_BLOCKS),
        .WIDTH (1)
    ) u_flags (
        .clk   (clk),
        .we    (flag_ram_we),
        .waddr (flag_ram_waddr),
        .wdata (flag_ram_wdata),
        .re    (accept),
        .raddr (idx_in_addr),
        .rdata (flag_rd)
    );

    pbrt_ram #(
        .DEPTH (MAX_BLOCKS),
        .WIDTH (AW)
    ) u_stack (
        .clk   (clk),
        .we    (exec_go && stack_we),
        .waddr (depth_addr),
        .wdata (idx_addr),
        .re    (accept),
        .raddr (depth_m1_addr),
        .rdata (stack_rd)
    );

    // Range and length checks
    assign parts_w    = W'(parts);
    assign in_range   = idx_w < parts_w;
    assign is_last    = (idx_w + 1'b1) == parts_w;
    assign need_len   = is_last ? last_len : LW'(BLOCK_BYTES);
    assign len_ok     = 17'(dlen_reg) == 17'(need_len);
    assign dlen_w     = 25'(dlen_reg);
    assign stack_rd_w = W'(stack_rd);
    assign fresh_w    = W'(fresh_reg);

    // Execute the latched item against the read data
    always_comb
    begin
        depth_next   = depth_reg;
        fresh_next   = fresh_reg;
        count_next   = count_reg;
        missing_next = missing_reg;
        sealed_next  = sealed_reg;
        status_next  = STAT_REFUSED;
        granted_next = '0;
        flag_we      = 1'b0;
        stack_we     = 1'b0;
        case (kind_reg)
            KIND_RESTART:
            begin
                depth_next   = '0;
                fresh_next   = '0;
                count_next   = '0;
                missing_next = eff_cur;
                sealed_next  = 1'b0;
                status_next  = STAT_OK;
            end
            KIND_RESERVE:
            begin
                if (!sealed_reg)
                begin
                    if (depth_reg != '0)
                    begin
                        depth_next   = depth_m1;
                        granted_next = stack_rd_w[9:0];
                        status_next  = STAT_OK;
                    end
                    else if (fresh_reg < parts)
                    begin
                        fresh_next   = fresh_reg + 1'b1;
                        granted_next = fresh_w[9:0];
                        status_next  = STAT_OK;
                    end
                end
            end
            KIND_CANCEL:
            begin
                if (!sealed_reg)
                begin
                    if (!in_range)
                    begin
                        status_next = STAT_RANGE;
                    end
                    else if (flag_rd)
                    begin
                        status_next = STAT_REFUSED;
                    end
                    else if (depth_reg >= DEPTH_MAX)
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        stack_we    = 1'b1;
                        depth_next  = depth_reg + 1'b1;
                        status_next = STAT_OK;
                    end
                end
            end
            KIND_STORE:
            begin
                if (!sealed_reg)
                begin
                    if (!in_range)
                    begin
                        status_next = STAT_RANGE;
                    end
                    else if (!len_ok)
                    begin
                        status_next = STAT_WRONG_LEN;
                    end
                    else
                    begin
                        if (!flag_rd)
                        begin
                            flag_we      = 1'b1;
                            count_next   = count_reg + 1'b1;
                            missing_next = (missing_reg >= dlen_w) ? missing_reg - dlen_w : '0;
                        end
                        status_next = STAT_OK;
                    end
                end
            end
            KIND_FLUSH:
            begin
                if (!sealed_reg && (count_reg == parts))
                begin
                    sealed_next = 1'b1;
                    depth_next  = '0;
                    status_next = STAT_OK;
                end
            end
            default:
            begin
                status_next = STAT_REFUSED;
            end
        endcase
    end

    // Hold tracker state; config write restarts it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg    <= PIECE_LEN_RESET;
            depth_reg   <= '0;
            fresh_reg   <= '0;
            count_reg   <= '0;
            missing_reg <= eff_length(PIECE_LEN_RESET, CAP);
            sealed_reg  <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            plen_reg    <= cfg_wr_data;
            depth_reg   <= '0;
            fresh_reg   <= '0;
            count_reg   <= '0;
            missing_reg <= eff_length(cfg_wr_data, CAP);
            sealed_reg  <= 1'b0;
        end
        else if (exec_go)
        begin
            depth_reg   <= depth_next;
            fresh_reg   <= fresh_next;
            count_reg   <= count_next;
            missing_reg <= missing_next;
            sealed_reg  <= sealed_next;
        end
    end

    // Latch the accepted item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= req.kind;
            idx_reg  <= req.block_index;
            dlen_reg <= req.data_length;
        end
    end

    // Sequence the states and register the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            rsp_valid_reg   <= 1'b0;
            status_reg      <= STAT_OK;
            granted_reg     <= '0;
            complete_reg    <= 1'b0;
            rsp_missing_reg <= '0;
            rsp_sealed_reg  <= 1'b0;
        end
        else
        begin
            if (exec_go)
            begin
                rsp_valid_reg   <= 1'b1;
                status_reg      <= status_next;
                granted_reg     <= granted_next;
                complete_reg    <= (count_next == parts);
                rsp_missing_reg <= missing_next;
                rsp_sealed_reg  <= sealed_next;
            end
            else if (rsp_valid_reg && rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (cfg_wr_en)
            begin
                state_reg <= ST_CLEAR;
            end
            else
            begin
                case (state_reg)
                    ST_IDLE:
                    begin
                        if (accept)
                        begin
                            state_reg <= ST_EXEC;
                        end
                    end
                    ST_EXEC:
                    begin
                        if (exec_go)
                        begin
                            state_reg <= restart_go ? ST_CLEAR : ST_IDLE;
                        end
                    end
                    ST_CLEAR:
                    begin
                        if (!sweep_active)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_reg <= ST_CLEAR;
                    end
                endcase
            end
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.status         = status_reg;
    assign rsp.granted_index  = granted_reg;
    assign rsp.piece_complete = complete_reg;
    assign rsp.missing_bytes  = rsp_missing_reg;
    assign rsp.sealed         = rsp_sealed_reg;

    // The cancel stack never grows past its capacity
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_MAX)
        else $error("cancel stack depth above capacity");

    // In the idle state, stored and handed-out counts stay within the block count
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (count_reg <= parts) && (fresh_reg <= parts))
        else $error("block counters exceed block count");

    // A sealed piece has every block stored
    a_sealed_complete: assert property (@(posedge clk) disable iff (!rst_n)
        (sealed_reg && (state_reg == ST_IDLE)) |-> (count_reg == parts))
        else $error("sealed piece is not complete");

    // A new result appears only after an execute step
    a_rsp_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_EXEC))
        else $error("result raised outside execute");

    // The sweep never runs while an item is being executed
    a_sweep_excl: assert property (@(posedge clk) disable iff (!rst_n)
        sweep_active |-> (state_reg == ST_CLEAR))
        else $error("flag sweep overlaps item execution");

endmodule
